### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every clock edge out of reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition that must never be true out of reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

### rtl/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg
// shared types and constants of the size class block allocator
// ----------------------------------------------------------------------------
package scba_pkg;

   // parameter defaults
   localparam int MAX_LEVELS_DEF      = 8;
   localparam int SLOTS_PER_LEVEL_DEF = 256;

   // field widths
   localparam int MIN_BLOCK_W = 17;
   localparam int LEVEL_CNT_W = 4;
   localparam int SIZE_W      = 24;
   localparam int RLVL_W      = 8;
   localparam int SLOT_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int OUT_LVL_W   = 3;
   localparam int BYTES_W     = 35;
   localparam int BLOCKS_W    = 12;

   // bus widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_DATA_W = MIN_BLOCK_W;

   // register reset values
   localparam logic [MIN_BLOCK_W-1:0] MIN_BLOCK_RST = MIN_BLOCK_W'(16);
   localparam logic [LEVEL_CNT_W-1:0] LEVEL_CNT_RST = LEVEL_CNT_W'(8);

   // running total limits
   localparam logic [BYTES_W-1:0]  BYTES_MAX  = '1;
   localparam logic [BLOCKS_W-1:0] BLOCKS_MAX = '1;

   typedef enum logic {
      KIND_ACQUIRE = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_MIN_BLOCK   = 1'b0,
      CSR_LEVEL_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 3'd0,
      STAT_BAD_SIZE    = 3'd1,
      STAT_OUT_OF_SLOT = 3'd2,
      STAT_BAD_LEVEL   = 3'd3,
      STAT_BAD_SLOT    = 3'd4,
      STAT_STACK_FULL  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOOKUP = 2'd1,
      ST_POP    = 2'd2
   } state_type;

endpackage

### rtl/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator
// hands out (level, slot) block handles from power-of-two size classes
// ----------------------------------------------------------------------------
// One transaction at a time. An acquire that pops a freed slot steps through
// accept, pointer read and stack read before its result is registered; every
// other transaction steps through accept and pointer read. The steps are set by
// the registered read of the per-class pointer ram followed, on a pop, by the
// read of the free stack ram; state is written back as the result is
// registered, so the next transaction reads up-to-date pointers. A finished
// result waits in the output register while the next request is accepted;
// that request only stalls at its write-back if the result is still untaken.
// No clearing pass after reset: pointer entries have valid bits and the
// stack store is only read where a push wrote it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module size_class_block_allocator import scba_pkg::*; #(
   parameter int MAX_LEVELS      = MAX_LEVELS_DEF,
   parameter int SLOTS_PER_LEVEL = SLOTS_PER_LEVEL_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // req_size[23:0] rel_level[31:24] rel_slot[39:32]
   input  logic                  req_tuser,  // kind (0 acquire, 1 release)
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // ok[0] status[3:1] out_level[6:4]
                                             // out_slot[14:7] bytes_in_use[49:15]
                                             // blocks_in_use[61:50] zero[63:62]
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int NLEV_W = $clog2(MAX_LEVELS + 1);
   localparam int CNT_W  = $clog2(SLOTS_PER_LEVEL + 1);
   localparam int IDX_W  = $clog2(SLOTS_PER_LEVEL);
   localparam int ST_DEPTH = MAX_LEVELS * SLOTS_PER_LEVEL;
   localparam int ST_AW  = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
   localparam int CS_W   = MIN_BLOCK_W + MAX_LEVELS - 1;

   // configuration registers
   logic [MIN_BLOCK_W-1:0] min_block_size_ff;
   logic [LEVEL_CNT_W-1:0] level_count_ff;
   logic [NLEV_W-1:0]      nlev;

   // request fields
   logic [SIZE_W-1:0] in_size;
   logic [RLVL_W-1:0] in_rel_level;
   logic [SLOT_W-1:0] in_rel_slot;
   kind_type          in_kind;

   // transaction in flight
   state_type         state_ff, state_in;
   kind_type          kind_ff;
   logic [LVL_W-1:0]  lvl_ff;
   logic              found_ff;
   logic              lvl_ok_ff;
   logic [SLOT_W-1:0] rel_slot_ff;

   // class search
   logic             sel_found;
   logic [LVL_W-1:0] sel_level;

   // pointer ram
   logic             ptr_rd_en;
   logic [LVL_W-1:0] ptr_rd_addr;
   logic [CNT_W-1:0] ptr_depth;
   logic [CNT_W-1:0] ptr_fresh;
   logic             ptr_wr_en;
   logic [CNT_W-1:0] ptr_wr_depth;
   logic [CNT_W-1:0] ptr_wr_fresh;

   // stack ram
   logic              st_wr_en;
   logic              st_rd_en;
   logic [IDX_W-1:0]  st_idx;
   logic [ST_AW-1:0]  st_addr;
   logic [SLOT_W-1:0] st_rd_data;

   // result path
   logic              accept;
   logic              out_free;
   logic              pop_path;
   logic              finish;
   status_type        res_status;
   logic [SLOT_W-1:0] res_slot;
   logic              use_add;
   logic              use_sub;
   logic [CS_W-1:0]   cls_size;
   logic [BYTES_W:0]  byte_sum;

   logic [BYTES_W-1:0]  byte_total_ff, byte_total_in;
   logic [BLOCKS_W-1:0] block_total_ff, block_total_in;

   logic                 rsp_valid_ff;
   logic                 rsp_ok_ff;
   status_type           rsp_status_ff;
   logic [OUT_LVL_W-1:0] rsp_level_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_block_size_ff <= MIN_BLOCK_RST;
         level_count_ff    <= LEVEL_CNT_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_BLOCK:   min_block_size_ff <= csr_wdata;
            CSR_LEVEL_COUNT: level_count_ff    <= csr_wdata[LEVEL_CNT_W-1:0];
            default:         ;
         endcase
      end
   end

   // classes in use, capped at the number built
   assign nlev = (32'(level_count_ff) > MAX_LEVELS) ? NLEV_W'(MAX_LEVELS)
                                                    : NLEV_W'(level_count_ff);

   // ---------------------------------------------------------------- request
   assign in_size      = req_tdata[23:0];
   assign in_rel_level = req_tdata[31:24];
   assign in_rel_slot  = req_tdata[39:32];
   assign in_kind      = kind_type'(req_tuser);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   scba_class_select #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_class_select (
      .req_size       (in_size),
      .min_block_size (min_block_size_ff),
      .nlev           (nlev),
      .found          (sel_found),
      .level          (sel_level)
   );

   // pointer read issued on accept, data lands in the lookup cycle
   assign ptr_rd_en   = accept;
   assign ptr_rd_addr = (in_kind == KIND_RELEASE) ? LVL_W'(in_rel_level) : sel_level;

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= in_kind;
         lvl_ff      <= ptr_rd_addr;
         found_ff    <= sel_found;
         lvl_ok_ff   <= (in_rel_level < RLVL_W'(nlev));
         rel_slot_ff <= in_rel_slot;
      end
   end

   scba_ptr_ram #(
      .MAX_LEVELS      (MAX_LEVELS),
      .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL)
   ) u_ptr_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (ptr_rd_en),
      .rd_addr  (ptr_rd_addr),
      .rd_depth (ptr_depth),
      .rd_fresh (ptr_fresh),
      .wr_en    (ptr_wr_en),
      .wr_addr  (lvl_ff),
      .wr_depth (ptr_wr_depth),
      .wr_fresh (ptr_wr_fresh)
   );

   scba_stack_ram #(
      .DEPTH (ST_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_addr),
      .wr_data (rel_slot_ff),
      .rd_en   (st_rd_en),
      .rd_addr (st_addr),
      .rd_data (st_rd_data)
   );

   // ---------------------------------------------------------------- control
   // output register can take a new result this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (pop_path) begin
               state_in = ST_POP;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop_path     = 1'b0;
      finish       = 1'b0;
      res_status   = STAT_OK;
      res_slot     = '0;
      use_add      = 1'b0;
      use_sub      = 1'b0;
      ptr_wr_en    = 1'b0;
      ptr_wr_depth = ptr_depth;
      ptr_wr_fresh = ptr_fresh;
      st_wr_en     = 1'b0;
      st_rd_en     = 1'b0;
      // pop reads the top entry, push writes just above it
      st_idx       = (kind_ff == KIND_RELEASE) ? IDX_W'(ptr_depth)
                                               : IDX_W'(ptr_depth - CNT_W'(1));
      case (state_ff)
         ST_LOOKUP: begin
            if (kind_ff == KIND_ACQUIRE) begin
               if (!found_ff) begin
                  res_status = STAT_BAD_SIZE;
               end else if (ptr_depth != '0) begin
                  pop_path = 1'b1;
                  st_rd_en = 1'b1;
               end else if (ptr_fresh < CNT_W'(SLOTS_PER_LEVEL)) begin
                  // issue the next never-used slot
                  res_slot     = SLOT_W'(ptr_fresh);
                  use_add      = 1'b1;
                  ptr_wr_en    = out_free;
                  ptr_wr_fresh = ptr_fresh + CNT_W'(1);
               end else begin
                  res_status = STAT_OUT_OF_SLOT;
               end
            end else begin
               if (!lvl_ok_ff) begin
                  res_status = STAT_BAD_LEVEL;
               end else if (32'(rel_slot_ff) >= 32'(ptr_fresh)) begin
                  res_status = STAT_BAD_SLOT;
               end else if (ptr_depth >= CNT_W'(SLOTS_PER_LEVEL)) begin
                  res_status = STAT_STACK_FULL;
               end else begin
                  use_sub      = 1'b1;
                  st_wr_en     = out_free;
                  ptr_wr_en    = out_free;
                  ptr_wr_depth = ptr_depth + CNT_W'(1);
               end
            end
            finish = !pop_path && out_free;
         end
         ST_POP: begin
            res_slot     = st_rd_data;
            use_add      = 1'b1;
            ptr_wr_en    = out_free;
            ptr_wr_depth = ptr_depth - CNT_W'(1);
            finish       = out_free;
         end
         default: ;
      endcase
   end

   assign st_addr = ST_AW'(ST_AW'(lvl_ff) * ST_AW'(SLOTS_PER_LEVEL) + ST_AW'(st_idx));

   // ---------------------------------------------------------------- totals
   assign cls_size = CS_W'(min_block_size_ff) << lvl_ff;
   assign byte_sum = {1'b0, byte_total_ff} + (BYTES_W + 1)'(cls_size);

   // saturating at zero and at the top of each counter
   always_comb begin
      byte_total_in  = byte_total_ff;
      block_total_in = block_total_ff;
      if (finish && use_add) begin
         byte_total_in = byte_sum[BYTES_W] ? BYTES_MAX : byte_sum[BYTES_W-1:0];
         if (block_total_ff != BLOCKS_MAX) begin
            block_total_in = block_total_ff + BLOCKS_W'(1);
         end
      end else if (finish && use_sub) begin
         byte_total_in = (byte_total_ff < BYTES_W'(cls_size)) ? '0
                         : byte_total_ff - BYTES_W'(cls_size);
         if (block_total_ff != '0) begin
            block_total_in = block_total_ff - BLOCKS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         byte_total_ff  <= '0;
         block_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         byte_total_ff  <= byte_total_in;
         block_total_ff <= block_total_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, handle fields zero unless granted
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ok_ff     <= (res_status == STAT_OK);
         rsp_status_ff <= res_status;
         rsp_level_ff  <= use_add ? OUT_LVL_W'(lvl_ff) : '0;
         rsp_slot_ff   <= use_add ? res_slot : '0;
      end
   end

   // ---------------------------------------------------------------- response
   // totals only move at finish, which waits for the held result to drain
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, block_total_ff, byte_total_ff, rsp_slot_ff,
                        rsp_level_ff, rsp_status_ff, rsp_ok_ff};

   // ---------------------------------------------------------------- checks
   `ASSERT_PROP(a_pop_after_lookup, clock, reset,
      (state_ff == ST_POP) |-> ($past(state_ff) == ST_LOOKUP || $past(state_ff) == ST_POP))
   `ASSERT_PROP(a_fail_has_no_handle, clock, reset,
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_level_ff == '0 && rsp_slot_ff == '0))
   `ASSERT_PROP(a_total_moves_on_finish, clock, reset,
      (block_total_ff != $past(block_total_ff)) |-> $past(finish))
   `ASSERT_NEVER(a_stack_rw_clash, clock, reset, st_wr_en && st_rd_en)

endmodule

### rtl/scba_class_select.sv
// ----------------------------------------------------------------------------
// scba_class_select
// finds the smallest size class that holds a request plus one byte
// ----------------------------------------------------------------------------
module scba_class_select import scba_pkg::*; #(
   parameter int MAX_LEVELS = MAX_LEVELS_DEF,
   localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
   localparam int NLEV_W = $clog2(MAX_LEVELS + 1)
) (
   input  logic [SIZE_W-1:0]      req_size,
   input  logic [MIN_BLOCK_W-1:0] min_block_size,
   input  logic [NLEV_W-1:0]      nlev,
   output logic                   found,
   output logic [LVL_W-1:0]       level
);

   localparam int CS_W  = MIN_BLOCK_W + MAX_LEVELS - 1;
   localparam int CMP_W = (CS_W > SIZE_W + 1) ? CS_W : SIZE_W + 1;

   logic [CMP_W-1:0] need;

   assign need = CMP_W'(req_size) + CMP_W'(1);

   // independent compare per class, lowest fitting class wins
   always_comb begin
      found = 1'b0;
      level = '0;
      for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
         if ((req_size != '0) && (NLEV_W'(i) < nlev) &&
             (need <= (CMP_W'(min_block_size) << i))) begin
            found = 1'b1;
            level = LVL_W'(i);
         end
      end
   end

endmodule

### rtl/scba_ptr_ram.sv
// ----------------------------------------------------------------------------
// scba_ptr_ram
// per class stack depth and fresh slot count, registered read
// ----------------------------------------------------------------------------
module scba_ptr_ram import scba_pkg::*; #(
   parameter int MAX_LEVELS      = MAX_LEVELS_DEF,
   parameter int SLOTS_PER_LEVEL = SLOTS_PER_LEVEL_DEF,
   localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
   localparam int CNT_W = $clog2(SLOTS_PER_LEVEL + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [LVL_W-1:0] rd_addr,
   output logic [CNT_W-1:0] rd_depth,
   output logic [CNT_W-1:0] rd_fresh,
   input  logic             wr_en,
   input  logic [LVL_W-1:0] wr_addr,
   input  logic [CNT_W-1:0] wr_depth,
   input  logic [CNT_W-1:0] wr_fresh
);

   logic [2*CNT_W-1:0]    ram_ff [MAX_LEVELS];
   logic [MAX_LEVELS-1:0] valid_ff;
   logic [2*CNT_W-1:0]    rd_data_ff;

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rd_data_ff <= '0;
      end else begin
         if (wr_en && (32'(wr_addr) < MAX_LEVELS)) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            if ((32'(rd_addr) < MAX_LEVELS) && valid_ff[rd_addr]) begin
               rd_data_ff <= ram_ff[rd_addr];
            end else begin
               rd_data_ff <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (32'(wr_addr) < MAX_LEVELS)) begin
         ram_ff[wr_addr] <= {wr_depth, wr_fresh};
      end
   end

   assign rd_depth = rd_data_ff[2*CNT_W-1:CNT_W];
   assign rd_fresh = rd_data_ff[CNT_W-1:0];

endmodule

### rtl/scba_stack_ram.sv
// ----------------------------------------------------------------------------
// scba_stack_ram
// free stack store of all classes, one write and one registered read port
// ----------------------------------------------------------------------------
module scba_stack_ram import scba_pkg::*; #(
   parameter int DEPTH = MAX_LEVELS_DEF * SLOTS_PER_LEVEL_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [SLOT_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [SLOT_W-1:0] rd_data
);

   logic [SLOT_W-1:0] ram_ff [DEPTH];
   logic [SLOT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
